### rtl/mil_pkg.sv
`timescale 1ns / 1ps

package mil_pkg;

  // fixed geometry of the box and its fields
  localparam int unsigned MAX_DIMS  = 3;
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned EXT_W     = 17;
  localparam int unsigned LIN_IN_W  = 48;
  localparam int unsigned LIN_OUT_W = 49;
  localparam int unsigned STR1_W    = 17;
  localparam int unsigned STR2_W    = 33;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_REGS  = 6;

  // conversion direction
  localparam logic MODE_TO_INDEX = 1'b0;
  localparam logic MODE_TO_COORD = 1'b1;

  // derived box geometry, shared by the datapath
  typedef struct packed {
    logic                                busy;
    logic [MAX_DIMS-1:0][COORD_W-1:0]    lo;
    logic [MAX_DIMS-1:0][EXT_W-1:0]      ext;
    logic [STR1_W-1:0]                   stride1;
    logic [STR2_W-1:0]                   stride2;
    logic [LIN_OUT_W-1:0]                total;
  } geom_t;

  // per-item data that rides alongside the divider
  typedef struct packed {
    logic                 mode;
    logic                 hit;
    logic [LIN_OUT_W-1:0] lin;
  } side_t;

endpackage

### rtl/multidim_index_linearizer_top.sv
`timescale 1ns / 1ps

// Converts between box coordinates and a linear index (dimension 0 fastest),
// one item per cycle in either direction. Every item runs the same pipeline:
// two stages of offset, stride product and sum, a row of 48 one-bit divider
// cells that divide the index by the top stride, a row of 33 cells that
// divide the remainder by the next stride, and the output register.
// A stalled output holds the whole row, so throughput is one item per cycle
// while out_ready_i stays high and the tables are idle. After each bound write
// the tables are rebuilt, during which in_ready_o and cfg_ready_o are low.
module multidim_index_linearizer_top import mil_pkg::*; #(
  parameter int unsigned DIMS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [COORD_W-1:0]            cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic signed [COORD_W-1:0]     coord_in_0_i,
  input  logic signed [COORD_W-1:0]     coord_in_1_i,
  input  logic signed [COORD_W-1:0]     coord_in_2_i,
  input  logic [LIN_IN_W-1:0]           linear_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [LIN_OUT_W-1:0]   linear_out_o,
  output logic signed [COORD_W-1:0]     coord_out_0_o,
  output logic signed [COORD_W-1:0]     coord_out_1_o,
  output logic signed [COORD_W-1:0]     coord_out_2_o,
  output logic                          inside_res_o
);

  localparam int unsigned SIDE_A_W = $bits(side_t);
  localparam int unsigned SIDE_B_W = $bits(side_t) + COORD_W;

  geom_t                             geom;
  logic                              en;
  logic                              f_valid;
  side_t                             f_side;
  logic [LIN_IN_W-1:0]               f_idx;
  logic [STR2_W-1:0]                 div_a;
  logic [STR1_W-1:0]                 div_b;
  logic                              a_valid;
  logic [LIN_IN_W-1:0]               a_num;
  logic [STR2_W-1:0]                 a_rem;
  logic [SIDE_A_W-1:0]               a_side;
  logic                              b_valid;
  logic [STR2_W-1:0]                 b_num;
  logic [STR1_W-1:0]                 b_rem;
  logic [SIDE_B_W-1:0]               b_side;
  side_t                             sb;
  logic [COORD_W-1:0]                qa, qb, rb;
  logic [MAX_DIMS-1:0][COORD_W-1:0]  coord_d, coord_q;
  logic [LIN_OUT_W-1:0]              lin_d, lin_q;
  logic                              inside_q;
  logic                              out_valid_q;

  // whole row advances unless a finished result is held
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en && !geom.busy;

  mil_tables #(.DIMS(DIMS)) u_tables (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .geom_o     (geom)
  );

  mil_front #(.DIMS(DIMS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i && in_ready_o),
    .mode_i  (mode_i),
    .coord_i ({coord_in_2_i, coord_in_1_i, coord_in_0_i}),
    .linear_i(linear_in_i),
    .geom_i  (geom),
    .valid_o (f_valid),
    .side_o  (f_side),
    .idx_o   (f_idx)
  );

  // divisors: stride of the top dimension, then the middle one
  assign div_a = (DIMS >= 3) ? geom.stride2 :
                 (DIMS == 2) ? STR2_W'(geom.stride1) : STR2_W'(1);
  assign div_b = (DIMS >= 3) ? geom.stride1 : STR1_W'(1);

  mil_div_chain #(
    .NUM_W (LIN_IN_W),
    .DIV_W (STR2_W),
    .SIDE_W(SIDE_A_W)
  ) u_chain_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (f_valid),
    .num_i    (f_idx),
    .side_i   (f_side),
    .divisor_i(div_a),
    .valid_o  (a_valid),
    .num_o    (a_num),
    .rem_o    (a_rem),
    .side_o   (a_side)
  );

  mil_div_chain #(
    .NUM_W (STR2_W),
    .DIV_W (STR1_W),
    .SIDE_W(SIDE_B_W)
  ) u_chain_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (a_valid),
    .num_i    (a_rem),
    .side_i   ({a_side, a_num[COORD_W-1:0]}),
    .divisor_i(div_b),
    .valid_o  (b_valid),
    .num_o    (b_num),
    .rem_o    (b_rem),
    .side_o   (b_side)
  );

  assign sb = b_side[SIDE_B_W-1:COORD_W];
  assign qa = b_side[COORD_W-1:0];
  assign qb = b_num[COORD_W-1:0];
  assign rb = b_rem[COORD_W-1:0];

  // result fields per direction
  always_comb begin
    coord_d = '0;
    lin_d   = '0;
    if (sb.mode == MODE_TO_COORD) begin
      if (DIMS >= 3) begin
        coord_d[2] = qa + geom.lo[2];
        coord_d[1] = qb + geom.lo[1];
        coord_d[0] = rb + geom.lo[0];
      end else if (DIMS == 2) begin
        coord_d[1] = qa + geom.lo[1];
        coord_d[0] = qb + geom.lo[0];
      end else begin
        coord_d[0] = qa + geom.lo[0];
      end
    end else begin
      lin_d = sb.lin;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= b_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      coord_q  <= coord_d;
      lin_q    <= lin_d;
      inside_q <= sb.hit;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign linear_out_o  = $signed(lin_q);
  assign coord_out_0_o = $signed(coord_q[0]);
  assign coord_out_1_o = $signed(coord_q[1]);
  assign coord_out_2_o = $signed(coord_q[2]);
  assign inside_res_o  = inside_q;

`ifndef SYNTHESIS
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> !in_ready_o)
    else $error("input taken while tables rebuild");

  a_busy_from_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(geom.busy) |-> $past(cfg_valid_i && cfg_ready_o))
    else $error("table rebuild without a config transfer");

  a_out_from_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(b_valid))
    else $error("result shown without an item leaving the divider row");
`endif

endmodule

### rtl/mil_tables.sv
`timescale 1ns / 1ps

module mil_tables import mil_pkg::*; #(
  parameter int unsigned DIMS = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  output geom_t                geom_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXT  = 4'b0010,
    ST_STR  = 4'b0100,
    ST_TOT  = 4'b1000
  } drv_state_e;

  drv_state_e state_q, state_d;
  logic [NUM_REGS-1:0][COORD_W-1:0] bound_q;
  logic [MAX_DIMS-1:0][COORD_W-1:0] lo_c, lo_q;
  logic [MAX_DIMS-1:0][EXT_W-1:0]   ext_c, ext_q;
  logic [STR1_W-1:0]                s1_q;
  logic [STR2_W-1:0]                s2_q, pre_q;
  logic [LIN_OUT_W-1:0]             total_q;
  logic [2*EXT_W-1:0]               prod01;
  logic [STR2_W+EXT_W-1:0]          prod_tot;
  logic                             cfg_fire;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  // bound registers, writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= '0;
    end else if (cfg_fire && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
      bound_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // derivation sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (cfg_fire) state_d = ST_EXT;
      ST_EXT:  state_d = ST_STR;
      ST_STR:  state_d = ST_TOT;
      ST_TOT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ordered ends and extent per dimension
  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_dim
    logic signed [COORD_W-1:0] a, b, mn, mx;
    logic signed [EXT_W-1:0]   span;
    assign a    = $signed(bound_q[2*g]);
    assign b    = $signed(bound_q[2*g+1]);
    assign mn   = (a < b) ? a : b;
    assign mx   = (a < b) ? b : a;
    assign span = $signed({mx[COORD_W-1], mx}) - $signed({mn[COORD_W-1], mn});
    assign lo_c[g]  = mn;
    assign ext_c[g] = (g < DIMS) ? (EXT_W'(span) + EXT_W'(1)) : EXT_W'(1);
  end

  assign prod01   = ext_q[0] * ext_q[1];
  assign prod_tot = pre_q * ext_q[2];

  // derived tables, one product per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q    <= '0;
      ext_q   <= {MAX_DIMS{EXT_W'(1)}};
      s1_q    <= STR1_W'(1);
      s2_q    <= STR2_W'(1);
      pre_q   <= STR2_W'(1);
      total_q <= LIN_OUT_W'(1);
    end else begin
      unique case (state_q)
        ST_EXT: begin
          lo_q  <= lo_c;
          ext_q <= ext_c;
        end
        ST_STR: begin
          s1_q  <= (DIMS >= 2) ? ext_q[0] : STR1_W'(1);
          pre_q <= prod01[STR2_W-1:0];
          s2_q  <= (DIMS >= 3) ? prod01[STR2_W-1:0] : STR2_W'(1);
        end
        ST_TOT: begin
          total_q <= prod_tot[LIN_OUT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign geom_o.busy    = (state_q != ST_IDLE);
  assign geom_o.lo      = lo_q;
  assign geom_o.ext     = ext_q;
  assign geom_o.stride1 = s1_q;
  assign geom_o.stride2 = s2_q;
  assign geom_o.total   = total_q;

endmodule

### rtl/mil_front.sv
`timescale 1ns / 1ps

module mil_front import mil_pkg::*; #(
  parameter int unsigned DIMS = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic                              mode_i,
  input  logic [MAX_DIMS-1:0][COORD_W-1:0]  coord_i,
  input  logic [LIN_IN_W-1:0]               linear_i,
  input  geom_t                             geom_i,
  output logic                              valid_o,
  output side_t                             side_o,
  output logic [LIN_IN_W-1:0]               idx_o
);

  logic [MAX_DIMS-1:0][LIN_OUT_W-1:0] prod_c, prod_q;
  logic [MAX_DIMS-1:0]                box_c;
  logic                               inside_c;
  logic                               v1_q, mode1_q, inside1_q;
  logic [LIN_IN_W-1:0]                idx1_q;
  logic                               v2_q;
  side_t                              side2_q;
  logic [LIN_IN_W-1:0]                idx2_q;

  // offset, box test and stride product per dimension
  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_dim
    logic signed [EXT_W-1:0]          off;
    logic signed [STR2_W:0]           str;
    logic signed [STR2_W+EXT_W:0]     prod;
    logic                             in_box;
    assign off = $signed({coord_i[g][COORD_W-1], coord_i[g]})
               - $signed({geom_i.lo[g][COORD_W-1], geom_i.lo[g]});
    if (g == 0) begin : g_s0
      assign str = (STR2_W+1)'(1);
    end else if (g == 1) begin : g_s1
      assign str = $signed({1'b0, STR2_W'(geom_i.stride1)});
    end else begin : g_s2
      assign str = $signed({1'b0, geom_i.stride2});
    end
    assign prod   = off * str;
    assign in_box = !off[EXT_W-1] && ({1'b0, off[EXT_W-2:0]} < geom_i.ext[g]);
    assign prod_c[g] = (g < DIMS) ? prod[LIN_OUT_W-1:0] : '0;
    assign box_c[g]  = (g < DIMS) ? in_box : 1'b1;
  end

  assign inside_c = (mode_i == MODE_TO_COORD) ? ({1'b0, linear_i} < geom_i.total)
                                              : (&box_c);

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // products, then their sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q       <= prod_c;
      mode1_q      <= mode_i;
      inside1_q    <= inside_c;
      idx1_q       <= linear_i;
      side2_q.mode <= mode1_q;
      side2_q.hit  <= inside1_q;
      side2_q.lin  <= prod_q[0] + prod_q[1] + prod_q[2];
      idx2_q       <= idx1_q;
    end
  end

  assign valid_o = v2_q;
  assign side_o  = side2_q;
  assign idx_o   = idx2_q;

endmodule

### rtl/mil_div_cell.sv
`timescale 1ns / 1ps

module mil_div_cell #(
  parameter int unsigned NUM_W  = 48,
  parameter int unsigned DIV_W  = 33,
  parameter int unsigned SIDE_W = 51
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DIV_W-1:0]  rem_i,
  input  logic [SIDE_W-1:0] side_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  num_o,
  output logic [DIV_W-1:0]  rem_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] diff;
  logic             qbit;
  logic             valid_q;
  logic [NUM_W-1:0] num_q;
  logic [DIV_W-1:0] rem_q;
  logic [SIDE_W-1:0] side_q;

  // one restoring step: bring down the top dividend bit, try a subtract
  assign shifted = {rem_i, num_i[NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_i};
  assign qbit    = !diff[DIV_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= {num_i[NUM_W-2:0], qbit};
      rem_q  <= qbit ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign rem_o   = rem_q;
  assign side_o  = side_q;

endmodule

### rtl/mil_div_chain.sv
`timescale 1ns / 1ps

module mil_div_chain #(
  parameter int unsigned NUM_W  = 48,
  parameter int unsigned DIV_W  = 33,
  parameter int unsigned SIDE_W = 51
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [SIDE_W-1:0] side_i,
  input  logic [DIV_W-1:0]  divisor_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  num_o,
  output logic [DIV_W-1:0]  rem_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NUM_W:0]              valid_w;
  logic [NUM_W:0][NUM_W-1:0]   num_w;
  logic [NUM_W:0][DIV_W-1:0]   rem_w;
  logic [NUM_W:0][SIDE_W-1:0]  side_w;

  assign valid_w[0] = valid_i;
  assign num_w[0]   = num_i;
  assign rem_w[0]   = '0;
  assign side_w[0]  = side_i;

  // one cell per quotient bit, most significant first
  for (genvar k = 0; k < NUM_W; k++) begin : g_cell
    mil_div_cell #(
      .NUM_W (NUM_W),
      .DIV_W (DIV_W),
      .SIDE_W(SIDE_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en_i),
      .valid_i  (valid_w[k]),
      .num_i    (num_w[k]),
      .rem_i    (rem_w[k]),
      .side_i   (side_w[k]),
      .divisor_i(divisor_i),
      .valid_o  (valid_w[k+1]),
      .num_o    (num_w[k+1]),
      .rem_o    (rem_w[k+1]),
      .side_o   (side_w[k+1])
    );
  end

  assign valid_o = valid_w[NUM_W];
  assign num_o   = num_w[NUM_W];
  assign rem_o   = rem_w[NUM_W];
  assign side_o  = side_w[NUM_W];

endmodule

### tb/multidim_index_linearizer_top_tb.sv
`timescale 1ns / 1ps

module multidim_index_linearizer_top_tb;
  import mil_pkg::*;

  localparam bit [63:0] MASK49 = 64'h1_FFFF_FFFF_FFFF;
  localparam bit [63:0] MASK48 = 64'h0_FFFF_FFFF_FFFF;
  localparam bit [63:0] MASK17 = 64'h1_FFFF;
  localparam int unsigned DRAIN_CYCLES = 100;

  // bound register indexes, plus two that lie beyond the list
  localparam bit [CFG_IDX_W-1:0] REG_LOW_0   = CFG_IDX_W'(0);
  localparam bit [CFG_IDX_W-1:0] REG_HIGH_0  = CFG_IDX_W'(1);
  localparam bit [CFG_IDX_W-1:0] REG_LOW_1   = CFG_IDX_W'(2);
  localparam bit [CFG_IDX_W-1:0] REG_HIGH_1  = CFG_IDX_W'(3);
  localparam bit [CFG_IDX_W-1:0] REG_LOW_2   = CFG_IDX_W'(4);
  localparam bit [CFG_IDX_W-1:0] REG_HIGH_2  = CFG_IDX_W'(5);
  localparam bit [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(NUM_REGS);
  localparam bit [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(NUM_REGS + 1);

  typedef struct {
    bit [LIN_OUT_W-1:0] linear;
    bit [COORD_W-1:0]   coord [MAX_DIMS];
    bit                 hit;
  } conv_result_t;

  // box model: bound registers, derived tables and pending conversions
  class lin_scoreboard;
    bit [COORD_W-1:0] bounds [NUM_REGS];
    bit [63:0]        extent [MAX_DIMS];
    bit [63:0]        stride [MAX_DIMS];
    bit [63:0]        total;
    conv_result_t     pending [$];
    int               mismatches;
    int               checked;

    function new();
      foreach (bounds[i]) bounds[i] = '0;
      mismatches = 0;
      checked = 0;
      rebuild();
    endfunction

    function longint dim_lo(int d);
      longint a, b;
      a = $signed(bounds[2*d]);
      b = $signed(bounds[2*d+1]);
      return (a < b) ? a : b;
    endfunction

    function longint dim_hi(int d);
      longint a, b;
      a = $signed(bounds[2*d]);
      b = $signed(bounds[2*d+1]);
      return (a < b) ? b : a;
    endfunction

    // extents, strides and item count from the current bounds
    function void rebuild();
      bit [63:0] prod;
      prod = 1;
      for (int d = 0; d < MAX_DIMS; d++) begin
        extent[d] = 64'(dim_hi(d) - dim_lo(d) + 1) & MASK17;
        prod = (prod * extent[d]) & MASK49;
      end
      total = prod;
      stride[0] = 1;
      for (int d = 1; d < MAX_DIMS; d++)
        stride[d] = (stride[d-1] * extent[d-1]) & MASK49;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [COORD_W-1:0] data);
      if (idx < NUM_REGS) begin
        bounds[idx] = data;
        rebuild();
      end
    endfunction

    // accepted input transfer: predict its conversion
    function void note_input(bit mode, bit [COORD_W-1:0] c0, bit [COORD_W-1:0] c1,
                             bit [COORD_W-1:0] c2, bit [LIN_IN_W-1:0] lin);
      conv_result_t r;
      bit [COORD_W-1:0] cin [MAX_DIMS];
      bit [63:0] acc, idx, p, q;
      longint c;
      cin[0] = c0;
      cin[1] = c1;
      cin[2] = c2;
      r.linear = '0;
      foreach (r.coord[d]) r.coord[d] = '0;
      r.hit = 1'b1;
      if (mode == MODE_TO_INDEX) begin
        acc = 0;
        for (int d = 0; d < MAX_DIMS; d++) begin
          c = $signed(cin[d]);
          if (c < dim_lo(d) || c > dim_hi(d)) r.hit = 1'b0;
          acc = acc + 64'(c - dim_lo(d)) * stride[d];
        end
        r.linear = acc[LIN_OUT_W-1:0];
      end else begin
        idx = 64'(lin) & MASK48;
        r.hit = (idx < total);
        for (int d = MAX_DIMS - 1; d >= 0; d--) begin
          p = (stride[d] == 0) ? 64'd1 : stride[d];
          q = idx / p;
          idx = idx % p;
          r.coord[d] = COORD_W'(q + 64'(dim_lo(d)));
        end
      end
      pending.push_back(r);
    endfunction

    // accepted output transfer: compare with the oldest prediction
    function void check_result(bit [LIN_OUT_W-1:0] lin, bit [COORD_W-1:0] c0,
                               bit [COORD_W-1:0] c1, bit [COORD_W-1:0] c2, bit hit);
      conv_result_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
        return;
      end
      e = pending.pop_front();
      if (e.linear !== lin || e.coord[0] !== c0 || e.coord[1] !== c1 ||
          e.coord[2] !== c2 || e.hit !== hit) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: exp lin=%h c=%h,%h,%h in=%b got lin=%h c=%h,%h,%h in=%b",
                   $realtime, e.linear, e.coord[0], e.coord[1], e.coord[2], e.hit,
                   lin, c0, c1, c2, hit);
      end
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i;
  logic [COORD_W-1:0]          cfg_data_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic                        mode_i;
  logic signed [COORD_W-1:0]   coord_in_0_i;
  logic signed [COORD_W-1:0]   coord_in_1_i;
  logic signed [COORD_W-1:0]   coord_in_2_i;
  logic [LIN_IN_W-1:0]         linear_in_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic signed [LIN_OUT_W-1:0] linear_out_o;
  logic signed [COORD_W-1:0]   coord_out_0_o;
  logic signed [COORD_W-1:0]   coord_out_1_o;
  logic signed [COORD_W-1:0]   coord_out_2_o;
  logic                        inside_res_o;

  lin_scoreboard sb = new();
  int idle_pct;
  int stall_pct;
  bit hold_req;
  int items_sent;
  int cfg_writes;

  multidim_index_linearizer_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .coord_in_0_i (coord_in_0_i),
    .coord_in_1_i (coord_in_1_i),
    .coord_in_2_i (coord_in_2_i),
    .linear_in_i  (linear_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .linear_out_o (linear_out_o),
    .coord_out_0_o(coord_out_0_o),
    .coord_out_1_o(coord_out_1_o),
    .coord_out_2_o(coord_out_2_o),
    .inside_res_o (inside_res_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // monitor: sample every transfer at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o)
        sb.note_input(mode_i, coord_in_0_i, coord_in_1_i, coord_in_2_i, linear_in_i);
      if (out_valid_o && out_ready_i)
        sb.check_result(linear_out_o, coord_out_0_o, coord_out_1_o, coord_out_2_o,
                        inside_res_o);
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one input transfer, with random gaps ahead of it
  task automatic send_item(bit mode, bit [COORD_W-1:0] c0, bit [COORD_W-1:0] c1,
                           bit [COORD_W-1:0] c2, bit [LIN_IN_W-1:0] lin);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mode_i       <= mode;
    coord_in_0_i <= c0;
    coord_in_1_i <= c1;
    coord_in_2_i <= c2;
    linear_in_i  <= lin;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // stop offering and let every pending conversion come back
  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0 && guard < 400000) begin
      @(posedge clk_i);
      guard++;
    end
    if (guard >= 400000) begin
      $display("RESULT: ERROR");
      $finish;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(bit [CFG_IDX_W-1:0] idx, bit [COORD_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_box(int l0, int h0, int l1, int h1, int l2, int h2);
    drain();
    write_cfg(REG_LOW_0, COORD_W'(l0));
    write_cfg(REG_HIGH_0, COORD_W'(h0));
    write_cfg(REG_LOW_1, COORD_W'(l1));
    write_cfg(REG_HIGH_1, COORD_W'(h1));
    write_cfg(REG_LOW_2, COORD_W'(l2));
    write_cfg(REG_HIGH_2, COORD_W'(h2));
  endtask

  // random conversion, mostly near the box or around the item count
  task automatic rand_item();
    bit mode;
    bit [COORD_W-1:0] c [MAX_DIMS];
    bit [63:0] lin;
    int sel;
    mode = 1'($urandom_range(1));
    sel = $urandom_range(9);
    for (int d = 0; d < MAX_DIMS; d++) begin
      if (mode == MODE_TO_INDEX && sel < 7)
        c[d] = COORD_W'(sb.dim_lo(d) + longint'($urandom_range(int'(sb.extent[d]) + 3)) - 2);
      else
        c[d] = COORD_W'($urandom);
    end
    lin = {$urandom, $urandom};
    if (mode == MODE_TO_COORD) begin
      if (sel < 6) lin = lin % sb.total;
      else if (sel < 8) lin = sb.total + $urandom_range(2) - 1;
    end
    send_item(mode, c[0], c[1], c[2], LIN_IN_W'(lin));
  endtask

  task automatic corner_items();
    send_item(MODE_TO_INDEX, 16'h8000, 16'h8000, 16'h8000, '0);
    send_item(MODE_TO_INDEX, 16'h7fff, 16'h7fff, 16'h7fff, '1);
    send_item(MODE_TO_INDEX, COORD_W'(sb.dim_lo(0)), COORD_W'(sb.dim_lo(1)),
              COORD_W'(sb.dim_lo(2)), '0);
    send_item(MODE_TO_INDEX, COORD_W'(sb.dim_hi(0)), COORD_W'(sb.dim_hi(1)),
              COORD_W'(sb.dim_hi(2)), '0);
    send_item(MODE_TO_INDEX, COORD_W'(sb.dim_hi(0) + 1), COORD_W'(sb.dim_hi(1)),
              COORD_W'(sb.dim_lo(2) - 1), '0);
    send_item(MODE_TO_COORD, '1, '1, '1, '0);
    send_item(MODE_TO_COORD, '0, '0, '0, '1);
    send_item(MODE_TO_COORD, '0, '0, '0, LIN_IN_W'(sb.total - 1));
    send_item(MODE_TO_COORD, '0, '0, '0, LIN_IN_W'(sb.total));
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    mode_i       = MODE_TO_INDEX;
    coord_in_0_i = '0;
    coord_in_1_i = '0;
    coord_in_2_i = '0;
    linear_in_i  = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    items_sent   = 0;
    cfg_writes   = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset box, a small reversed box, the full range
    corner_items();
    set_box(-3, 4, 5, 2, 1, -1);
    write_cfg(REG_SPARE_A, 16'h1234);
    write_cfg(REG_SPARE_B, 16'hffff);
    corner_items();
    set_box(-32768, 32767, 32767, -32768, -32768, 32767);
    corner_items();

    // random batches with changing flow control and boxes
    for (int b = 0; b < 30; b++) begin
      if (b % 4 == 0 && b > 0) begin
        case (b / 4)
          1: set_box(32767, 32767, -32768, -32768, 0, 0);
          2: set_box(-32768, 32767, 0, 0, 7, -7);
          3: set_box(0, 0, 0, 0, 0, 0);
          default: begin
            int l [MAX_DIMS];
            foreach (l[d]) l[d] = $urandom_range(65535) - 32768;
            set_box(l[0], l[0] + $urandom_range(40) - 20, l[1], l[1] - $urandom_range(20),
                    l[2], l[2] + $urandom_range(30));
          end
        endcase
      end
      case (b % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 75; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      if (b == 5 || b == 20) begin
        idle_pct = 0;
        hold_req = 1'b1;
      end
      repeat (60) rand_item();
      if (b == 13) drain();
    end

    drain();
    $display("covered %0d conversions in both directions, %0d bound writes", items_sent,
             cfg_writes);
    $display("boxes: reset, reversed, full range, degenerate, random; under varied flow");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches of %0d results", sb.mismatches, sb.checked);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
